FILE: rtl/core/eba_pkg.sv
// Shared types, codes and constants of the effect block allocator.
`timescale 1ns / 1ps

package eba_pkg;

  localparam int DEFAULT_SLOT_COUNT = 16;

  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int CODE_W      = 8;
  localparam int EIDX_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int POOL_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_CONTROL = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_CREATE = 2'd2;

  localparam logic [CODE_W-1:0]  CTRL_ENABLE    = 8'h01;
  localparam logic [CODE_W-1:0]  CTRL_DISABLE   = 8'h02;
  localparam logic [CODE_W-1:0]  CTRL_RESET     = 8'h04;
  localparam logic [INDEX_W-1:0] FREE_ALL_INDEX = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_SIZE = 1'd1;

  localparam logic [POOL_W-1:0] POOL_SIZE_RESET   = 16'd4096;
  localparam logic [POOL_W-1:0] EFFECT_SIZE_RESET = 16'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/eba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module eba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/effect_block_allocator.sv
// Top level of the effect block allocator: slot bitmap, search hint and pool counter.
//
// Usage: the host side presents one request item on the req channel (kind,
// block_index, control_code) with req_valid; it is taken at a clock edge where
// req_valid is high and req_stall is low. Every item yields exactly one item on
// the rsp channel (effect_index, load_status, pool_available, actuators_enabled),
// which is taken where rsp_valid is high and rsp_stall is low.
// The block handles one item at a time. Free all, device control and pool query
// items go straight to the emit state, from which their result is loaded into
// the output register as soon as it is free. A single block free reads the slot
// bitmap memory before it writes it back, and then goes to the emit state. A create
// examines one slot per cycle from the search hint upward, reading the registered
// bitmap memory, and stops at the first unused slot or at the last slot; with the
// hint at the top it runs no scan. The next item can be taken in the cycle in
// which rsp_valid rises.
// A finished result sits in the output register while the receiver stalls it.
// The block still takes one more item meanwhile, but holds that item's result
// and takes nothing further until the output register has been emptied.
// The configuration port must write pool_size and effect_size only while the block
// is idle (not enforced). Free all, reset control, query refill pool to pool_size.
// Synchronous reset empties the bitmap at once (per-slot valid flops are
// cleared), sets the hint to 1, loads the pool with 4096 bytes, turns the
// actuators off and restores the register defaults. No clearing pass is needed.
`timescale 1ns / 1ps

module effect_block_allocator
  import eba_pkg::*;
#(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [INDEX_W-1:0]     block_index,
  input  logic [CODE_W-1:0]      control_code,
  // Response channel
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [EIDX_W-1:0]      effect_index,
  output logic [STATUS_W-1:0]    load_status,
  output logic [POOL_W-1:0]      pool_available,
  output logic                   actuators_enabled
);

  // Address width of the bitmap and width of the hint, which can reach SLOT_COUNT.
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int PW = $clog2(SLOT_COUNT + 1);
  localparam logic [PW-1:0]      SLOT_LIMIT     = PW'(SLOT_COUNT);
  localparam logic [INDEX_W:0]   SLOT_LIMIT_IDX = (INDEX_W + 1)'(SLOT_COUNT);
  localparam logic [PW-1:0]      HINT_START     = PW'(1);

  // Architectural state.
  state_t                state, state_next;
  logic [PW-1:0]         hint, hint_next;
  logic [POOL_W-1:0]     pool_left, pool_next;
  logic                  actuator_on, act_next;
  logic [SLOT_COUNT-1:0] slot_valid, valid_next;
  logic [POOL_W-1:0]     pool_size, effect_size;

  // Item in flight.
  logic [AW-1:0]         free_idx, free_idx_next;
  logic [EIDX_W-1:0]     pend_index, pend_index_next;
  logic [STATUS_W-1:0]   pend_status, pend_status_next;
  logic                  load_rsp;

  // Bitmap memory access.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic                  ram_wdata, ram_rdata;
  logic                  rd_vld;

  // Decoded conditions.
  logic                  hint_full;
  logic [PW-1:0]         hint_inc;
  logic                  scan_end;
  logic                  free_ok;
  logic                  cur_used;
  logic                  rsp_free;
  logic [POOL_W:0]       pool_sum;

  eba_ram #(
    .WIDTH(1),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // An entry not written since the bitmap was last cleared reads as unused.
  assign cur_used  = ram_rdata & rd_vld;
  assign hint_full = (hint >= SLOT_LIMIT);
  assign hint_inc  = hint + HINT_START;
  assign scan_end  = (hint_inc >= SLOT_LIMIT);
  assign free_ok   = (block_index != '0) && ({1'b0, block_index} < SLOT_LIMIT_IDX);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign pool_sum  = {1'b0, pool_left} + {1'b0, effect_size};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (kind_t'(kind))
            KIND_CREATE: begin
              state_next = hint_full ? ST_EMIT : ST_SCAN;
            end
            KIND_FREE: begin
              if (block_index != FREE_ALL_INDEX && free_ok) begin
                state_next = ST_FREE;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!cur_used || scan_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_FREE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath control and next values.
  always_comb begin
    req_stall        = (state != ST_IDLE);
    ram_we           = 1'b0;
    ram_waddr        = hint[AW-1:0];
    ram_wdata        = 1'b0;
    ram_raddr        = hint[AW-1:0];
    hint_next        = hint;
    pool_next        = pool_left;
    act_next         = actuator_on;
    valid_next       = slot_valid;
    free_idx_next    = free_idx;
    pend_index_next  = pend_index;
    pend_status_next = pend_status;
    load_rsp         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          pend_index_next  = '0;
          pend_status_next = STATUS_NOT_CREATE;
          case (kind_t'(kind))
            KIND_CREATE: begin
              // With the hint at the top the table is full; no scan is run.
              if (hint_full) begin
                pend_status_next = STATUS_FULL;
              end
            end
            KIND_FREE: begin
              if (block_index == FREE_ALL_INDEX) begin
                valid_next = '0;
                hint_next  = HINT_START;
                pool_next  = pool_size;
              end else if (free_ok) begin
                ram_raddr     = block_index[AW-1:0];
                free_idx_next = block_index[AW-1:0];
              end
            end
            KIND_CONTROL: begin
              if (control_code == CTRL_ENABLE) begin
                act_next = 1'b1;
              end else if (control_code == CTRL_DISABLE) begin
                act_next = 1'b0;
              end else if (control_code == CTRL_RESET) begin
                valid_next = '0;
                hint_next  = HINT_START;
                pool_next  = pool_size;
              end
            end
            default: begin
              // Pool query releases everything.
              valid_next = '0;
              hint_next  = HINT_START;
              pool_next  = pool_size;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!cur_used) begin
          ram_we                  = 1'b1;
          ram_waddr               = hint[AW-1:0];
          ram_wdata               = 1'b1;
          valid_next[hint[AW-1:0]] = 1'b1;
          pend_index_next         = EIDX_W'(32'(hint));
          pend_status_next        = STATUS_OK;
          pool_next = (pool_left > effect_size) ? (pool_left - effect_size) : '0;
        end else begin
          hint_next = hint_inc;
          ram_raddr = hint_inc[AW-1:0];
          if (scan_end) begin
            pend_status_next = STATUS_FULL;
          end
        end
      end
      ST_FREE: begin
        if (cur_used) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = 1'b0;
          if (PW'(free_idx) < hint) begin
            hint_next = PW'(free_idx);
          end
          pool_next = pool_sum[POOL_W] ? '1 : pool_sum[POOL_W-1:0];
        end
      end
      ST_EMIT: begin
        load_rsp = rsp_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      hint        <= HINT_START;
      pool_left   <= POOL_SIZE_RESET;
      actuator_on <= 1'b0;
      slot_valid  <= '0;
      pool_size   <= POOL_SIZE_RESET;
      effect_size <= EFFECT_SIZE_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      hint        <= hint_next;
      pool_left   <= pool_next;
      actuator_on <= act_next;
      slot_valid  <= valid_next;
      if (cfg_we) begin
        if (cfg_index == REG_POOL_SIZE) begin
          pool_size <= cfg_data;
        end else if (cfg_index == REG_EFFECT_SIZE) begin
          effect_size <= cfg_data;
        end
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    free_idx    <= free_idx_next;
    pend_index  <= pend_index_next;
    pend_status <= pend_status_next;
    rd_vld      <= slot_valid[ram_raddr];
    if (load_rsp) begin
      effect_index      <= pend_index;
      load_status       <= pend_status;
      pool_available    <= pool_left;
      actuators_enabled <= actuator_on;
    end
  end

`ifndef SYNTHESIS
  // The hint always stays within slot 1 up to one past the last slot.
  assert property (@(posedge clk) disable iff (rst)
    (hint >= HINT_START) && (hint <= SLOT_LIMIT))
    else $error("search hint out of range");

  // A scan only ever runs on a real slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (hint < SLOT_LIMIT))
    else $error("scan past the last slot");

  // A waiting result reaches the output as soon as the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !rsp_valid) |=> (rsp_valid && state == ST_IDLE))
    else $error("result not delivered");
`endif

endmodule
